[rtl/core/pitm_pkg.sv]
// Shared constants and types for the point-in-triangle margin test.
package pitm_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int MARGIN_W        = 31;
  localparam int MARGIN_SQ_W     = 2 * MARGIN_W;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 4;
  localparam int REG_INDEX_W     = 2;

  localparam logic [REG_INDEX_W-1:0] REG_MARGIN_AB = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_MARGIN_BC = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_MARGIN_CA = 2'd2;

  typedef struct packed {
    logic [MARGIN_W-1:0] ab;
    logic [MARGIN_W-1:0] bc;
    logic [MARGIN_W-1:0] ca;
  } margin_set_t;

  typedef struct packed {
    logic valid;
    logic pass;
    logic deg;
  } lane_result_t;

endpackage

[rtl/core/pitm_cfg_regs.sv]
// APB register file holding the three per-edge margins.
module pitm_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pitm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pitm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pitm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output pitm_pkg::margin_set_t              margins
);

  logic [pitm_pkg::MARGIN_W-1:0]    margin_ab_r, margin_ab_nxt;
  logic [pitm_pkg::MARGIN_W-1:0]    margin_bc_r, margin_bc_nxt;
  logic [pitm_pkg::MARGIN_W-1:0]    margin_ca_r, margin_ca_nxt;
  logic [pitm_pkg::REG_INDEX_W-1:0] reg_index;
  logic                             wr_en;
  logic [pitm_pkg::MARGIN_W-1:0]    wr_value;

  assign pready    = 1'b1;
  assign reg_index = paddr[pitm_pkg::APB_ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite && pready;
  assign wr_value  = pwdata[pitm_pkg::MARGIN_W-1:0];

  always_comb begin
    margin_ab_nxt = margin_ab_r;
    margin_bc_nxt = margin_bc_r;
    margin_ca_nxt = margin_ca_r;
    if (wr_en) begin
      case (reg_index)
        pitm_pkg::REG_MARGIN_AB: margin_ab_nxt = wr_value;
        pitm_pkg::REG_MARGIN_BC: margin_bc_nxt = wr_value;
        pitm_pkg::REG_MARGIN_CA: margin_ca_nxt = wr_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_ab_r <= '0;
      margin_bc_r <= '0;
      margin_ca_r <= '0;
    end else begin
      margin_ab_r <= margin_ab_nxt;
      margin_bc_r <= margin_bc_nxt;
      margin_ca_r <= margin_ca_nxt;
    end
  end

  always_comb begin
    case (reg_index)
      pitm_pkg::REG_MARGIN_AB: prdata = {1'b0, margin_ab_r};
      pitm_pkg::REG_MARGIN_BC: prdata = {1'b0, margin_bc_r};
      pitm_pkg::REG_MARGIN_CA: prdata = {1'b0, margin_ca_r};
      default:                 prdata = '0;
    endcase
  end

  assign margins.ab = margin_ab_r;
  assign margins.bc = margin_bc_r;
  assign margins.ca = margin_ca_r;

endmodule

[rtl/core/pitm_edge_lane.sv]
// Seven-stage pipeline that tests one directed edge against its margin.
module pitm_edge_lane #(
  parameter int COORD_WIDTH = pitm_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [COORD_WIDTH-1:0]        start_x,
  input  logic signed [COORD_WIDTH-1:0]        start_y,
  input  logic signed [COORD_WIDTH-1:0]        end_x,
  input  logic signed [COORD_WIDTH-1:0]        end_y,
  input  logic signed [COORD_WIDTH-1:0]        point_x,
  input  logic signed [COORD_WIDTH-1:0]        point_y,
  input  logic [pitm_pkg::MARGIN_W-1:0]        margin,
  output pitm_pkg::lane_result_t               result
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int H   = DW;
  localparam int NW  = 2 * DW;
  localparam int MW  = pitm_pkg::MARGIN_W;
  localparam int MSW = pitm_pkg::MARGIN_SQ_W;
  localparam int PW  = MW + H;
  localparam int N2W = 2 * NW;
  localparam int RW  = MSW + NW;
  localparam int CW  = (N2W > RW) ? N2W : RW;

  logic               v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  logic signed [DW-1:0] dx_r, dy_r, qx_r, qy_r;
  logic signed [DW-1:0] dx_nxt, dy_nxt, qx_nxt, qy_nxt;

  logic                 deg2_r, deg2_nxt;
  logic signed [NW-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic [NW-1:0]        sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [MSW-1:0]       mm2_r, mm2_nxt;

  logic                 deg3_r;
  logic signed [NW:0]   n3_r, n3_nxt;
  logic [NW-1:0]        l2_3_r, l2_3_nxt;
  logic [MSW-1:0]       mm3_r;

  logic                 deg4_r, pos4_r, pos4_nxt;
  logic [NW:0]          n_neg;
  logic [NW-1:0]        nmag4_r, nmag4_nxt;
  logic [NW-1:0]        l2_4_r;
  logic [MSW-1:0]       mm4_r;

  logic                 deg5_r, pos5_r;
  logic [NW-1:0]        hh_r, hl_r, ll_r, hh_nxt, hl_nxt, ll_nxt;
  logic [PW-1:0]        rhh_r, rhl_r, rlh_r, rll_r;
  logic [PW-1:0]        rhh_nxt, rhl_nxt, rlh_nxt, rll_nxt;

  logic                 deg6_r, pos6_r;
  logic [CW-1:0]        n2_r, rhs_r, n2_nxt, rhs_nxt;

  logic                 pass7_r, deg7_r, pass7_nxt;

  always_comb begin
    dx_nxt = $signed({end_x[COORD_WIDTH-1], end_x}) - $signed({start_x[COORD_WIDTH-1], start_x});
    dy_nxt = $signed({end_y[COORD_WIDTH-1], end_y}) - $signed({start_y[COORD_WIDTH-1], start_y});
    qx_nxt = $signed({point_x[COORD_WIDTH-1], point_x})
           - $signed({start_x[COORD_WIDTH-1], start_x});
    qy_nxt = $signed({point_y[COORD_WIDTH-1], point_y})
           - $signed({start_y[COORD_WIDTH-1], start_y});
  end

  always_comb begin
    deg2_nxt = (dx_r == '0) && (dy_r == '0);
    p1_nxt   = dy_r * qx_r;
    p2_nxt   = dx_r * qy_r;
    sqx_nxt  = dx_r * dx_r;
    sqy_nxt  = dy_r * dy_r;
    mm2_nxt  = margin * margin;
  end

  always_comb begin
    n3_nxt   = p1_r - p2_r;
    l2_3_nxt = sqx_r + sqy_r;
  end

  always_comb begin
    n_neg     = -n3_r;
    pos4_nxt  = !n3_r[NW] && (n3_r != '0);
    nmag4_nxt = n3_r[NW] ? n_neg[NW-1:0] : n3_r[NW-1:0];
  end

  always_comb begin
    hh_nxt  = nmag4_r[NW-1:H] * nmag4_r[NW-1:H];
    hl_nxt  = nmag4_r[NW-1:H] * nmag4_r[H-1:0];
    ll_nxt  = nmag4_r[H-1:0] * nmag4_r[H-1:0];
    rhh_nxt = mm4_r[MSW-1:MW] * l2_4_r[NW-1:H];
    rhl_nxt = mm4_r[MSW-1:MW] * l2_4_r[H-1:0];
    rlh_nxt = mm4_r[MW-1:0] * l2_4_r[NW-1:H];
    rll_nxt = mm4_r[MW-1:0] * l2_4_r[H-1:0];
  end

  always_comb begin
    n2_nxt  = (CW'(hh_r) << (2 * H)) + (CW'(hl_r) << (H + 1)) + CW'(ll_r);
    rhs_nxt = (CW'(rhh_r) << (MW + H)) + (CW'(rhl_r) << MW)
            + (CW'(rlh_r) << H) + CW'(rll_r);
  end

  always_comb begin
    pass7_nxt = !deg6_r && !pos6_r && (n2_r >= rhs_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    qx_r    <= qx_nxt;
    qy_r    <= qy_nxt;

    deg2_r  <= deg2_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    mm2_r   <= mm2_nxt;

    deg3_r  <= deg2_r;
    n3_r    <= n3_nxt;
    l2_3_r  <= l2_3_nxt;
    mm3_r   <= mm2_r;

    deg4_r  <= deg3_r;
    pos4_r  <= pos4_nxt;
    nmag4_r <= nmag4_nxt;
    l2_4_r  <= l2_3_r;
    mm4_r   <= mm3_r;

    deg5_r  <= deg4_r;
    pos5_r  <= pos4_r;
    hh_r    <= hh_nxt;
    hl_r    <= hl_nxt;
    ll_r    <= ll_nxt;
    rhh_r   <= rhh_nxt;
    rhl_r   <= rhl_nxt;
    rlh_r   <= rlh_nxt;
    rll_r   <= rll_nxt;

    deg6_r  <= deg5_r;
    pos6_r  <= pos5_r;
    n2_r    <= n2_nxt;
    rhs_r   <= rhs_nxt;

    deg7_r  <= deg6_r;
    pass7_r <= pass7_nxt;
  end

  assign result.valid = v7_r;
  assign result.pass  = pass7_r;
  assign result.deg   = deg7_r;

endmodule

[rtl/core/point_in_triangle_margin.sv]
// Top level of the point-in-triangle margin test with its APB margin registers.
//
// A word is accepted at each rising edge where start is high and busy is low.
// The word carries the three triangle vertices and the query point. Busy stays
// low, so a new word may be accepted in every cycle.
// Each edge a->b, b->c and c->a runs in its own seven-stage lane that forms the
// exact edge numerator, its square and the squared margin times the squared
// edge length, using multipliers no wider than the coordinate width plus one.
// The three lane results are combined in one output register.
// A word accepted at an edge passes through its lane stages and the output
// register; out_strobe is high for one cycle with the result on the out_ ports.
// Throughput is one word per cycle, set by the fully pipelined lanes.
// out_inside_res is 1 when the point lies inward of every edge by at least its
// margin; out_degenerate is 1 when an edge has zero length, and then
// out_inside_res is 0.
// The user writes the margins over APB at byte addresses 0, 4 and 8 only while
// no word is in flight; the block does not enforce it. Reset clears margins and
// all valid bits. The receiver cannot stall, so results are never held back.
module point_in_triangle_margin #(
  parameter int COORD_WIDTH = pitm_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [COORD_WIDTH-1:0]    in_vertex_a_x,
  input  logic signed [COORD_WIDTH-1:0]    in_vertex_a_y,
  input  logic signed [COORD_WIDTH-1:0]    in_vertex_b_x,
  input  logic signed [COORD_WIDTH-1:0]    in_vertex_b_y,
  input  logic signed [COORD_WIDTH-1:0]    in_vertex_c_x,
  input  logic signed [COORD_WIDTH-1:0]    in_vertex_c_y,
  input  logic signed [COORD_WIDTH-1:0]    in_query_x,
  input  logic signed [COORD_WIDTH-1:0]    in_query_y,
  output logic                             out_strobe,
  output logic                             out_inside_res,
  output logic                             out_degenerate,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pitm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pitm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pitm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  pitm_pkg::margin_set_t  margins;
  pitm_pkg::lane_result_t res_ab, res_bc, res_ca;
  logic                   in_accept;
  logic                   out_strobe_r, out_inside_r, out_deg_r;
  logic                   out_inside_nxt, out_deg_nxt;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  pitm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .margins (margins)
  );

  pitm_edge_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_ab (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .start_x  (in_vertex_a_x),
    .start_y  (in_vertex_a_y),
    .end_x    (in_vertex_b_x),
    .end_y    (in_vertex_b_y),
    .point_x  (in_query_x),
    .point_y  (in_query_y),
    .margin   (margins.ab),
    .result   (res_ab)
  );

  pitm_edge_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_bc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .start_x  (in_vertex_b_x),
    .start_y  (in_vertex_b_y),
    .end_x    (in_vertex_c_x),
    .end_y    (in_vertex_c_y),
    .point_x  (in_query_x),
    .point_y  (in_query_y),
    .margin   (margins.bc),
    .result   (res_bc)
  );

  pitm_edge_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_ca (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_accept),
    .start_x  (in_vertex_c_x),
    .start_y  (in_vertex_c_y),
    .end_x    (in_vertex_a_x),
    .end_y    (in_vertex_a_y),
    .point_x  (in_query_x),
    .point_y  (in_query_y),
    .margin   (margins.ca),
    .result   (res_ca)
  );

  always_comb begin
    out_deg_nxt    = res_ab.deg || res_bc.deg || res_ca.deg;
    out_inside_nxt = !out_deg_nxt && res_ab.pass && res_bc.pass && res_ca.pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= res_ab.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_inside_r <= out_inside_nxt;
    out_deg_r    <= out_deg_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_inside_res = out_inside_r;
  assign out_degenerate = out_deg_r;

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (res_ab.valid == res_bc.valid) && (res_ab.valid == res_ca.valid))
    else $error("edge lanes lost valid alignment");

  a_strobe_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_accept, 8))
    else $error("result strobe without a word accepted eight cycles earlier");

  a_inside_not_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_inside_res |-> !out_degenerate)
    else $error("inside reported for a degenerate triangle");

endmodule
